@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL. Define NO_ASSERTIONS to
// compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ sv/gcl_pkg.sv @@
// ---------------------------------------------------------------------------
// gcl_pkg
// Types and constants of the GCD / LCM unit.
// ---------------------------------------------------------------------------
package gcl_pkg;

   // number of operand bits used (2..16); the operand fields carry 16 bits
   localparam int OPERAND_WIDTH   = 16;
   localparam int OPERAND_FIELD_W = 16;
   localparam int DIVISOR_W       = 16;
   localparam int MULTIPLE_W      = 32;

   localparam int OP_W    = (OPERAND_WIDTH < OPERAND_FIELD_W) ? OPERAND_WIDTH
                                                               : OPERAND_FIELD_W;
   localparam int SHIFT_W = $clog2(OP_W);
   localparam int CNT_W   = $clog2(OP_W + 1);

   typedef struct packed {
      logic [OPERAND_FIELD_W-1:0] operand_a;
      logic [OPERAND_FIELD_W-1:0] operand_b;
   } gcl_req_type;

   typedef struct packed {
      logic [DIVISOR_W-1:0]  divisor;
      logic [MULTIPLE_W-1:0] multiple;
      logic                  zero_operand;
   } gcl_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic gcd_step;
      logic scale;
      logic div_step;
      logic mul;
   } gcl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic gcd_done;
      logic div_done;
      logic zero_operand;
   } gcl_stat_type;

endpackage

@@ sv/gcl_dpath.sv @@
// ---------------------------------------------------------------------------
// gcl_dpath
// Binary GCD reduction, restoring divider for a/gcd and the final multiply.
// ---------------------------------------------------------------------------
module gcl_dpath (
   input  logic                 clock,
   input  gcl_pkg::gcl_cmd_type cmd,
   input  gcl_pkg::gcl_req_type req_data,
   output gcl_pkg::gcl_stat_type stat,
   output gcl_pkg::gcl_rsp_type rsp_data
);
   import gcl_pkg::*;

   logic [OP_W-1:0]    a_ff, a_in;       // dividend, then quotient
   logic [OP_W-1:0]    b_ff, b_in;
   logic [OP_W-1:0]    x_ff, x_in;
   logic [OP_W-1:0]    y_ff, y_in;
   logic [SHIFT_W-1:0] k_ff, k_in;       // common power of two
   logic [OP_W-1:0]    g_ff, g_in;
   logic [OP_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [2*OP_W-1:0]  prod_ff, prod_in;
   logic               zero_ff, zero_in;

   logic [OP_W-1:0]    op_a, op_b;
   logic [OP_W:0]      trial;
   logic [OP_W:0]      trial_diff;
   logic               q_bit;

   assign op_a = req_data.operand_a[OP_W-1:0];
   assign op_b = req_data.operand_b[OP_W-1:0];

   assign trial      = {rem_ff, a_ff[OP_W-1]};
   assign trial_diff = trial - {1'b0, g_ff};
   assign q_bit      = (trial >= {1'b0, g_ff});

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      k_in    = k_ff;
      g_in    = g_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      prod_in = prod_ff;
      zero_in = zero_ff;

      if (cmd.load) begin
         a_in    = op_a;
         b_in    = op_b;
         x_in    = op_a;
         y_in    = op_b;
         k_in    = '0;
         zero_in = (op_a == '0) || (op_b == '0);
      end

      if (cmd.gcd_step) begin
         priority if (!x_ff[0] && !y_ff[0]) begin
            x_in = x_ff >> 1;
            y_in = y_ff >> 1;
            k_in = k_ff + SHIFT_W'(1);
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            // both odd: the difference is even
            x_in = (x_ff - y_ff) >> 1;
         end else begin
            y_in = (y_ff - x_ff) >> 1;
         end
      end

      if (cmd.scale) begin
         g_in   = (x_ff | y_ff) << k_ff;
         rem_in = '0;
         cnt_in = '0;
      end

      if (cmd.div_step) begin
         rem_in = q_bit ? trial_diff[OP_W-1:0] : trial[OP_W-1:0];
         a_in   = {a_ff[OP_W-2:0], q_bit};
         cnt_in = cnt_ff + CNT_W'(1);
      end

      if (cmd.mul) begin
         prod_in = (2*OP_W)'(a_ff) * (2*OP_W)'(b_ff);
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      k_ff    <= k_in;
      g_ff    <= g_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      zero_ff <= zero_in;
   end

   assign stat.gcd_done     = (x_ff == '0) || (y_ff == '0);
   assign stat.div_done     = (cnt_ff == CNT_W'(OP_W));
   assign stat.zero_operand = zero_ff;

   assign rsp_data.divisor      = zero_ff ? '0 : DIVISOR_W'(g_ff);
   assign rsp_data.multiple     = zero_ff ? '0 : MULTIPLE_W'(prod_ff);
   assign rsp_data.zero_operand = zero_ff;

endmodule

@@ sv/gcl_ctrl.sv @@
// ---------------------------------------------------------------------------
// gcl_ctrl
// Sequencer: load, GCD loop, scale, divide loop, multiply, result strobe.
// ---------------------------------------------------------------------------
module gcl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  gcl_pkg::gcl_stat_type stat,
   output gcl_pkg::gcl_cmd_type  cmd,
   output logic                  busy,
   output logic                  rsp_strobe
);
   import gcl_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_GCD   = 6'b000010,
      S_SCALE = 6'b000100,
      S_DIV   = 6'b001000,
      S_MUL   = 6'b010000,
      S_DONE  = 6'b100000
   } gcl_state_type;

   gcl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (stat.gcd_done) begin
               state_in = stat.zero_operand ? S_DONE : S_SCALE;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (stat.div_done) begin
               state_in = S_MUL;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_DONE);

endmodule

@@ sv/gcd_lcm_unit.sv @@
// ---------------------------------------------------------------------------
// gcd_lcm_unit
// Greatest common divisor and least common multiple of two unsigned operands.
// ---------------------------------------------------------------------------
//  channel   ports                      transfer
//  request   start, busy, req_data      rising edge with start high, busy low
//  result    rsp_strobe, rsp_data       every cycle rsp_strobe is high
//
//  One item at a time; busy stays high from the accepted start to the strobe.
//  Each item runs through load, the binary GCD steps, the GCD exit, scale,
//  the divide steps, the divide exit, multiply and strobe. Only the number
//  of binary GCD steps depends on the operands; a zero operand goes from
//  the GCD exit straight to the strobe, skipping scale, divide and multiply.
//  Synchronous reset returns the sequencer to idle. The result is shown for
//  one cycle only; the receiver cannot stall it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gcd_lcm_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  gcl_pkg::gcl_req_type req_data,
   output logic                 rsp_strobe,
   output gcl_pkg::gcl_rsp_type rsp_data
);
   import gcl_pkg::*;

   gcl_cmd_type  cmd;
   gcl_stat_type stat;
   logic         rsp_zero_fields;
   logic         rsp_valid_fields;

   gcl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   gcl_dpath u_dpath (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   assign rsp_zero_fields  = (rsp_data.divisor == '0) && (rsp_data.multiple == '0);
   assign rsp_valid_fields = (rsp_data.divisor != '0);

   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `ASSERT_IMPLY(a_zero_results, clock, reset, rsp_strobe && rsp_data.zero_operand, rsp_zero_fields)
   `ASSERT_IMPLY(a_divisor_nonzero, clock, reset, rsp_strobe && !rsp_data.zero_operand, rsp_valid_fields)

endmodule
